// ===== design/fpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fpt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_W          = 48;

  // sqrt(3)/2 with 32 fraction bits.
  localparam logic [63:0] SQRT3_HALF_Q32 = 64'd3719550787;

  typedef struct packed {
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
    logic signed [15:0] p3_x;
    logic signed [15:0] p3_y;
  } fpt_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic                    valid_res;
  } fpt_out_t;

  typedef struct packed {
    logic vld;
    logic ok;
  } fpt_tag_t;

endpackage
`default_nettype wire

// ===== design/fpt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpt_div #(
  parameter int WN = 110,
  parameter int WD = 73
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fpt_pkg::fpt_tag_t              tag_i,
  input  logic signed [WN-1:0]           nx_i,
  input  logic signed [WN-1:0]           ny_i,
  input  logic signed [WD-1:0]           d_i,
  output fpt_pkg::fpt_tag_t              tag_o,
  output logic signed [fpt_pkg::OUT_W-1:0] qx_o,
  output logic signed [fpt_pkg::OUT_W-1:0] qy_o
);
  import fpt_pkg::*;

  localparam int QW = OUT_W;
  localparam int WR = (WN > WD + QW + 1) ? WN : WD + QW + 1;

  // Truncated quotient magnitude to a saturated signed result.
  function automatic logic signed [QW-1:0] sat(input logic [QW-1:0] q, input logic neg,
                                               input logic ovf);
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    hi = {1'b0, {(QW-1){1'b1}}};
    lo = {1'b1, {(QW-1){1'b0}}};
    if (neg) begin
      if (ovf || (q[QW-1] && (q[QW-2:0] != '0))) sat = lo;
      else sat = -$signed(q);
    end else begin
      if (ovf || q[QW-1]) sat = hi;
      else sat = $signed(q);
    end
  endfunction

  // Stage A: magnitudes and quotient signs.
  fpt_tag_t        tag_a_r;
  logic [WN-1:0]   anx_r, any_r;
  logic [WD-1:0]   ad_r;
  logic            negx_a_r, negy_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
    end else begin
      tag_a_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    anx_r    <= nx_i[WN-1] ? WN'(-nx_i) : WN'(nx_i);
    any_r    <= ny_i[WN-1] ? WN'(-ny_i) : WN'(ny_i);
    ad_r     <= d_i[WD-1] ? WD'(-d_i) : WD'(d_i);
    negx_a_r <= nx_i[WN-1] ^ d_i[WD-1];
    negy_a_r <= ny_i[WN-1] ^ d_i[WD-1];
  end

  // Stage B plus one restoring step per stage, most significant bit first.
  // The last step only needs the quotient bit, so the remainder and the
  // divisor stop one stage earlier.
  fpt_tag_t        tag_s_r [0:QW];
  logic [WR-1:0]   remx_s_r [0:QW-1];
  logic [WR-1:0]   remy_s_r [0:QW-1];
  logic [QW-1:0]   qx_s_r [0:QW];
  logic [QW-1:0]   qy_s_r [0:QW];
  logic [WD-1:0]   ad_s_r [0:QW-1];
  logic            negx_s_r [0:QW];
  logic            negy_s_r [0:QW];
  logic            ovfx_s_r [0:QW];
  logic            ovfy_s_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_s_r[0] <= '0;
    end else begin
      tag_s_r[0] <= tag_a_r;
    end
  end

  always_ff @(posedge clk) begin
    remx_s_r[0] <= WR'(anx_r);
    remy_s_r[0] <= WR'(any_r);
    qx_s_r[0]   <= '0;
    qy_s_r[0]   <= '0;
    ad_s_r[0]   <= ad_r;
    negx_s_r[0] <= negx_a_r;
    negy_s_r[0] <= negy_a_r;
    ovfx_s_r[0] <= WR'(anx_r) >= (WR'(ad_r) << QW);
    ovfy_s_r[0] <= WR'(any_r) >= (WR'(ad_r) << QW);
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int K = QW - 1 - j;
    logic [WR-1:0] sh;
    logic          gex, gey;

    assign sh  = WR'(ad_s_r[j]) << K;
    assign gex = remx_s_r[j] >= sh;
    assign gey = remy_s_r[j] >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_s_r[j+1] <= '0;
      end else begin
        tag_s_r[j+1] <= tag_s_r[j];
      end
    end

    always_ff @(posedge clk) begin
      qx_s_r[j+1]   <= qx_s_r[j] | (QW'(gex) << K);
      qy_s_r[j+1]   <= qy_s_r[j] | (QW'(gey) << K);
      negx_s_r[j+1] <= negx_s_r[j];
      negy_s_r[j+1] <= negy_s_r[j];
      ovfx_s_r[j+1] <= ovfx_s_r[j];
      ovfy_s_r[j+1] <= ovfy_s_r[j];
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        remx_s_r[j+1] <= gex ? remx_s_r[j] - sh : remx_s_r[j];
        remy_s_r[j+1] <= gey ? remy_s_r[j] - sh : remy_s_r[j];
        ad_s_r[j+1]   <= ad_s_r[j];
      end
    end
  end

  // Final stage: saturation, and zero for an invalid triangle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_o <= '0;
    end else begin
      tag_o <= tag_s_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    qx_o <= tag_s_r[QW].ok ? sat(qx_s_r[QW], negx_s_r[QW], ovfx_s_r[QW]) : '0;
    qy_o <= tag_s_r[QW].ok ? sat(qy_s_r[QW], negy_s_r[QW], ovfy_s_r[QW]) : '0;
  end

endmodule
`default_nettype wire

// ===== design/fermat_point_triangle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fermat point of a triangle by the equilateral apex construction.
// Input channel: a beat of three corners (in_data) is taken at each rising
// edge where start is high and busy is low. busy is always low, so a new
// triangle can be presented in every cycle.
// Result channel: out_valid is high for exactly one cycle per input beat and
// marks out_data, which carries the point in signed fixed point with
// FRAC_BITS fraction bits, saturated to 48 bits, plus valid_res. The receiver
// cannot hold results off, and nothing inside needs it to: the pipeline never
// stalls.
// Pipeline: ten arithmetic stages, then the 48-stage restoring divider
// with one setup stage, one compare stage and one saturation stage.
// Throughput: one triangle per cycle, set by the fully pipelined divider.
// Reset (rst_n low, synchronous) clears every valid bit; triangles in flight
// are dropped and no result leaves until new beats come through.
module fermat_point_triangle #(
  parameter int COORD_BITS = fpt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = fpt_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fpt_pkg::fpt_in_t  in_data,
  output logic              out_valid,
  output fpt_pkg::fpt_out_t out_data
);
  import fpt_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int WD1 = C + 1;          // corner differences
  localparam int WX  = 2 * WD1;        // side cross product terms
  localparam int WCR = WX + 1;         // side cross product
  localparam int WM  = C + F;          // edge midpoint
  localparam int WK  = C + F + 2;      // K times a difference
  localparam int WA  = C + F + 3;      // apex coordinate
  localparam int WU  = C + F + 4;      // direction vector component
  localparam int L1  = WU / 2;
  localparam int WP  = 2 * WU;
  localparam int WC  = 2 * WU + 1;     // line constants and determinant
  localparam int LC  = WC / 2;
  localparam int WQ  = WC + WU;
  localparam int WN  = WQ + 1;         // Cramer numerators
  localparam int LATENCY = 10 + OUT_W + 3;

  // sqrt(3)/2 rounded to nearest at F fraction bits.
  localparam logic [63:0] KW = (SQRT3_HALF_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [F:0]  KC = KW[F:0];

  // The pipeline never stalls, so the input side is always open.
  assign busy = 1'b0;

  // Stage 1: corners, reduced to COORD_BITS.
  logic                 v1_r;
  logic signed [C-1:0]  x1_1_r, y1_1_r, x2_1_r, y2_1_r, x3_1_r, y3_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x1_1_r <= C'(in_data.p1_x);
    y1_1_r <= C'(in_data.p1_y);
    x2_1_r <= C'(in_data.p2_x);
    y2_1_r <= C'(in_data.p2_y);
    x3_1_r <= C'(in_data.p3_x);
    y3_1_r <= C'(in_data.p3_y);
  end

  // Stage 2: edge differences, midpoints, side cross terms and K products.
  // Apex A sits on edge 1-2 away from corner 3, apex B on edge 2-3 away
  // from corner 1.
  logic                  v2_r;
  logic signed [WD1-1:0] dxa_nxt, dya_nxt, dxb_nxt, dyb_nxt;
  logic signed [WD1-1:0] ea_nxt, fa_nxt, eb_nxt, fb_nxt;
  logic signed [WD1-1:0] sx12_nxt, sy12_nxt, sx23_nxt, sy23_nxt;
  logic signed [WX-1:0]  pa1_nxt, pa2_nxt, pb1_nxt, pb2_nxt;
  logic signed [WX-1:0]  pa1_r, pa2_r, pb1_r, pb2_r;
  logic signed [WK-1:0]  kxa_nxt, kya_nxt, kxb_nxt, kyb_nxt;
  logic signed [WK-1:0]  kxa_r, kya_r, kxb_r, kyb_r;
  logic signed [WM-1:0]  mxa_r, mya_r, mxb_r, myb_r;
  logic signed [C-1:0]   x1_2_r, y1_2_r, x3_2_r, y3_2_r;

  always_comb begin
    dxa_nxt  = WD1'(x2_1_r) - WD1'(x1_1_r);
    dya_nxt  = WD1'(y2_1_r) - WD1'(y1_1_r);
    dxb_nxt  = WD1'(x3_1_r) - WD1'(x2_1_r);
    dyb_nxt  = WD1'(y3_1_r) - WD1'(y2_1_r);
    ea_nxt   = WD1'(y3_1_r) - WD1'(y1_1_r);
    fa_nxt   = WD1'(x3_1_r) - WD1'(x1_1_r);
    eb_nxt   = WD1'(y1_1_r) - WD1'(y2_1_r);
    fb_nxt   = WD1'(x1_1_r) - WD1'(x2_1_r);
    sx12_nxt = WD1'(x1_1_r) + WD1'(x2_1_r);
    sy12_nxt = WD1'(y1_1_r) + WD1'(y2_1_r);
    sx23_nxt = WD1'(x2_1_r) + WD1'(x3_1_r);
    sy23_nxt = WD1'(y2_1_r) + WD1'(y3_1_r);
    pa1_nxt  = dxa_nxt * ea_nxt;
    pa2_nxt  = dya_nxt * fa_nxt;
    pb1_nxt  = dxb_nxt * eb_nxt;
    pb2_nxt  = dyb_nxt * fb_nxt;
    kxa_nxt  = $signed({1'b0, KC}) * dxa_nxt;
    kya_nxt  = $signed({1'b0, KC}) * dya_nxt;
    kxb_nxt  = $signed({1'b0, KC}) * dxb_nxt;
    kyb_nxt  = $signed({1'b0, KC}) * dyb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pa1_r  <= pa1_nxt;
    pa2_r  <= pa2_nxt;
    pb1_r  <= pb1_nxt;
    pb2_r  <= pb2_nxt;
    kxa_r  <= kxa_nxt;
    kya_r  <= kya_nxt;
    kxb_r  <= kxb_nxt;
    kyb_r  <= kyb_nxt;
    mxa_r  <= WM'(sx12_nxt) <<< (F - 1);
    mya_r  <= WM'(sy12_nxt) <<< (F - 1);
    mxb_r  <= WM'(sx23_nxt) <<< (F - 1);
    myb_r  <= WM'(sy23_nxt) <<< (F - 1);
    x1_2_r <= x1_1_r;
    y1_2_r <= y1_1_r;
    x3_2_r <= x3_1_r;
    y3_2_r <= y3_1_r;
  end

  // Stage 3: the sign of each side cross product picks the apex side.
  logic                  v3_r, nz3_r;
  logic signed [WCR-1:0] cra_nxt, crb_nxt;
  logic                  posa_nxt, posb_nxt;
  logic signed [WA-1:0]  ax_r, ay_r, bx_r, by_r;
  logic signed [C-1:0]   x1_3_r, y1_3_r, x3_3_r, y3_3_r;

  always_comb begin
    cra_nxt  = WCR'(pa1_r) - WCR'(pa2_r);
    crb_nxt  = WCR'(pb1_r) - WCR'(pb2_r);
    posa_nxt = !cra_nxt[WCR-1] && (cra_nxt != '0);
    posb_nxt = !crb_nxt[WCR-1] && (crb_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    nz3_r  <= cra_nxt != '0;
    ax_r   <= posa_nxt ? WA'(mxa_r) + WA'(kya_r) : WA'(mxa_r) - WA'(kya_r);
    ay_r   <= posa_nxt ? WA'(mya_r) - WA'(kxa_r) : WA'(mya_r) + WA'(kxa_r);
    bx_r   <= posb_nxt ? WA'(mxb_r) + WA'(kyb_r) : WA'(mxb_r) - WA'(kyb_r);
    by_r   <= posb_nxt ? WA'(myb_r) - WA'(kxb_r) : WA'(myb_r) + WA'(kxb_r);
    x1_3_r <= x1_2_r;
    y1_3_r <= y1_2_r;
    x3_3_r <= x3_2_r;
    y3_3_r <= y3_2_r;
  end

  // Stage 4: direction vectors of the two lines, apex to far corner.
  logic                 v4_r, nz4_r;
  logic signed [WU-1:0] ux_r, uy_r, vx_r, vy_r;
  logic signed [WA-1:0] ax4_r, ay4_r, bx4_r, by4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    nz4_r <= nz3_r;
    ux_r  <= (WU'(x3_3_r) <<< F) - WU'(ax_r);
    uy_r  <= (WU'(y3_3_r) <<< F) - WU'(ay_r);
    vx_r  <= (WU'(x1_3_r) <<< F) - WU'(bx_r);
    vy_r  <= (WU'(y1_3_r) <<< F) - WU'(by_r);
    ax4_r <= ax_r;
    ay4_r <= ay_r;
    bx4_r <= bx_r;
    by4_r <= by_r;
  end

  // Stage 5: partial products for the line constants and the determinant.
  // The second operand is split into an unsigned low half and a signed
  // high half.
  logic                       v5_r, nz5_r;
  logic signed [WU-1:0]       ma [6];
  logic signed [WU-1:0]       mb [6];
  logic signed [WU+L1:0]      pl_r [6];
  logic signed [2*WU-L1-1:0]  ph_r [6];
  logic signed [WU-1:0]       ux5_r, uy5_r, vx5_r, vy5_r;

  always_comb begin
    ma[0] = uy_r;  mb[0] = WU'(ax4_r);
    ma[1] = ux_r;  mb[1] = WU'(ay4_r);
    ma[2] = vy_r;  mb[2] = WU'(bx4_r);
    ma[3] = vx_r;  mb[3] = WU'(by4_r);
    ma[4] = ux_r;  mb[4] = vy_r;
    ma[5] = uy_r;  mb[5] = vx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      pl_r[i] <= ma[i] * $signed({1'b0, mb[i][L1-1:0]});
      ph_r[i] <= ma[i] * $signed(mb[i][WU-1:L1]);
    end
    nz5_r <= nz4_r;
    ux5_r <= ux_r;
    uy5_r <= uy_r;
    vx5_r <= vx_r;
    vy5_r <= vy_r;
  end

  // Stage 6: partial products summed.
  logic                 v6_r, nz6_r;
  logic signed [WP-1:0] prod_r [6];
  logic signed [WU-1:0] ux6_r, uy6_r, vx6_r, vy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod_r[i] <= WP'(pl_r[i]) + (WP'(ph_r[i]) <<< L1);
    end
    nz6_r <= nz5_r;
    ux6_r <= ux5_r;
    uy6_r <= uy5_r;
    vx6_r <= vx5_r;
    vy6_r <= vy5_r;
  end

  // Stage 7: line constants and determinant. A zero determinant means the
  // construction lines are parallel.
  fpt_tag_t             tag7_r;
  logic signed [WC-1:0] det_nxt;
  logic signed [WC-1:0] c1_r, c2_r, det7_r;
  logic signed [WU-1:0] ux7_r, uy7_r, vx7_r, vy7_r;

  assign det_nxt = WC'(prod_r[4]) - WC'(prod_r[5]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag7_r <= '0;
    end else begin
      tag7_r.vld <= v6_r;
      tag7_r.ok  <= nz6_r && (det_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    c1_r   <= WC'(prod_r[0]) - WC'(prod_r[1]);
    c2_r   <= WC'(prod_r[2]) - WC'(prod_r[3]);
    det7_r <= det_nxt;
    ux7_r  <= ux6_r;
    uy7_r  <= uy6_r;
    vx7_r  <= vx6_r;
    vy7_r  <= vy6_r;
  end

  // Stage 8: four partial products for each numerator term; both the wide
  // constant and the vector component are split in halves.
  fpt_tag_t                      tag8_r;
  logic signed [WC-1:0]          ca [4];
  logic signed [WU-1:0]          cb [4];
  logic signed [LC+L1+1:0]       ll_r [4];
  logic signed [LC+WU-L1:0]      lh_r [4];
  logic signed [WC-LC+L1:0]      hl_r [4];
  logic signed [WC-LC+WU-L1-1:0] hh_r [4];
  logic signed [WC-1:0]          det8_r;

  always_comb begin
    ca[0] = c2_r;  cb[0] = ux7_r;
    ca[1] = c1_r;  cb[1] = vx7_r;
    ca[2] = c2_r;  cb[2] = uy7_r;
    ca[3] = c1_r;  cb[3] = vy7_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag8_r <= '0;
    end else begin
      tag8_r <= tag7_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      ll_r[i] <= $signed({1'b0, ca[i][LC-1:0]}) * $signed({1'b0, cb[i][L1-1:0]});
      lh_r[i] <= $signed({1'b0, ca[i][LC-1:0]}) * $signed(cb[i][WU-1:L1]);
      hl_r[i] <= $signed(ca[i][WC-1:LC]) * $signed({1'b0, cb[i][L1-1:0]});
      hh_r[i] <= $signed(ca[i][WC-1:LC]) * $signed(cb[i][WU-1:L1]);
    end
    det8_r <= det7_r;
  end

  // Stage 9: numerator terms.
  fpt_tag_t             tag9_r;
  logic signed [WQ-1:0] term_r [4];
  logic signed [WC-1:0] det9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag9_r <= '0;
    end else begin
      tag9_r <= tag8_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      term_r[i] <= WQ'(ll_r[i]) + (WQ'(lh_r[i]) <<< L1) + (WQ'(hl_r[i]) <<< LC)
                 + (WQ'(hh_r[i]) <<< (LC + L1));
    end
    det9_r <= det8_r;
  end

  // Stage 10: Cramer numerators for x and y.
  fpt_tag_t             tag10_r;
  logic signed [WN-1:0] nx_r, ny_r;
  logic signed [WC-1:0] det10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag10_r <= '0;
    end else begin
      tag10_r <= tag9_r;
    end
  end

  always_ff @(posedge clk) begin
    nx_r    <= WN'(term_r[0]) - WN'(term_r[1]);
    ny_r    <= WN'(term_r[2]) - WN'(term_r[3]);
    det10_r <= det9_r;
  end

  // Pipelined truncating division with saturation to the output range.
  fpt_tag_t                tag_o;
  logic signed [OUT_W-1:0] qx, qy;

  fpt_div #(
    .WN (WN),
    .WD (WC)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (tag10_r),
    .nx_i  (nx_r),
    .ny_i  (ny_r),
    .d_i   (det10_r),
    .tag_o (tag_o),
    .qx_o  (qx),
    .qy_o  (qy)
  );

  assign out_valid          = tag_o.vld;
  assign out_data.point_x   = qx;
  assign out_data.point_y   = qy;
  assign out_data.valid_res = tag_o.ok;

  // A result strobe always traces back to an accepted beat a fixed time ago.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching input beat");

  // A degenerate triangle seen in stage 3 leaves flagged invalid.
  a_collinear : assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !nz3_r) |-> ##(LATENCY - 3) (out_valid && !out_data.valid_res))
    else $error("collinear corners not flagged invalid");

endmodule
`default_nettype wire
